>>> sv/vjs_pkg.sv
// Shared types and constants of the velocity Jacobian stencil unit.
`default_nettype none

package vjs_pkg;

  localparam int SIZE_W     = 5;
  localparam int RECIP_W    = 16;
  localparam int VEL_W      = 16;
  localparam int JAC_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int STEP_W     = 3;

  localparam logic [SIZE_W-1:0]  SIZE_RESET  = 5'd16;
  localparam logic [RECIP_W-1:0] RECIP_RESET = 16'd256;

  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECIP_W = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RECIP_H = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RECIP_L = 3'd5;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_JAC  = 1'b1;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  localparam logic [STEP_W-1:0] STEP_LAST = 3'd5;

  typedef logic [8:0][JAC_W-1:0] jac_mat_t;

  typedef struct packed {
    logic              load;
    logic              rd_en;
    logic [STEP_W-1:0] rd_step;
    logic              publish;
  } vjs_cmd_t;

  typedef struct packed {
    logic load_done;
    logic row_done;
  } vjs_stat_t;

endpackage

`default_nettype wire

>>> sv/vjs_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none

module vjs_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

>>> sv/vjs_ctrl.sv
// Controller state machine: input/output handshakes and the read sequence.
`default_nettype none

module vjs_ctrl import vjs_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire logic      req_type,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire vjs_stat_t stat,
  output vjs_cmd_t       cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_PUB  = 4'b1000
  } state_t;

  state_t            state, state_next;
  logic [STEP_W-1:0] step, step_next;
  logic              accept;
  logic              pub_ok;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign pub_ok   = (state == ST_PUB) && (!out_valid || out_ready);

  assign cmd.load    = accept && (req_type == REQ_LOAD);
  assign cmd.rd_en   = (state == ST_READ);
  assign cmd.rd_step = step;
  assign cmd.publish = pub_ok;

  always_comb begin
    state_next = state;
    step_next  = step;
    unique case (state)
      ST_IDLE: begin
        step_next = '0;
        if (accept && req_type == REQ_JAC && stat.load_done) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        step_next = step + STEP_W'(1);
        if (step == STEP_LAST) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (stat.row_done) begin
          state_next = ST_PUB;
        end
      end
      ST_PUB: begin
        if (pub_ok) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      if (pub_ok) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/vjs_datapath.sv
// Datapath: configuration, grid counters, velocity RAM, difference and scaling pipeline.
`default_nettype none

module vjs_datapath import vjs_pkg::*; #(
  parameter int AXIS_MAX = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic        [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic        [CFG_DATA_W-1:0] cfg_data,
  input  wire logic signed [VEL_W-1:0]      vel_x,
  input  wire logic signed [VEL_W-1:0]      vel_y,
  input  wire logic signed [VEL_W-1:0]      vel_z,
  input  wire vjs_cmd_t                     cmd,
  output vjs_stat_t                         stat,
  output jac_mat_t                          jac,
  output logic                              last_cell
);

  localparam int DEPTH  = AXIS_MAX * AXIS_MAX * AXIS_MAX;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CRD_W  = $clog2(AXIS_MAX);
  localparam int ESZ_W  = $clog2(AXIS_MAX + 1);
  localparam int MEM_W  = 3 * VEL_W;
  localparam int DIFF_W = VEL_W + 1;
  localparam int PROD_W = DIFF_W + RECIP_W + 1;
  localparam logic [JAC_W-1:0] JAC_MAX = {1'b0, {(JAC_W-1){1'b1}}};
  localparam logic [JAC_W-1:0] JAC_MIN = {1'b1, {(JAC_W-1){1'b0}}};

  typedef struct packed {
    logic       valid;
    logic [1:0] axis;
    logic       hi;
    logic       interior;
  } rd_tag_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] axis;
    logic       interior;
  } ar_tag_t;

  function automatic logic [ESZ_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    logic [ESZ_W-1:0] r;
    if (s == '0) begin
      r = ESZ_W'(1);
    end else if (32'(s) > AXIS_MAX) begin
      r = ESZ_W'(AXIS_MAX);
    end else begin
      r = ESZ_W'(s);
    end
    return r;
  endfunction

  function automatic logic [JAC_W-1:0] sat_jac(input logic signed [PROD_W-1:0] v);
    logic [JAC_W-1:0] r;
    if (v[PROD_W-1:JAC_W-1] == '0 || v[PROD_W-1:JAC_W-1] == '1) begin
      r = v[JAC_W-1:0];
    end else if (v[PROD_W-1]) begin
      r = JAC_MIN;
    end else begin
      r = JAC_MAX;
    end
    return r;
  endfunction

  logic [SIZE_W-1:0]      size_cfg  [3];
  logic [RECIP_W-1:0]     recip_cfg [3];
  logic [ESZ_W-1:0]       eff       [3];
  logic [ESZ_W-1:0]       lim_m1    [3];
  logic [2*ESZ_W-1:0]     area;
  logic [ADDR_W-1:0]      stride_x;
  logic                   size_wr;

  logic [CRD_W-1:0]       lcrd [3];
  logic [CRD_W-1:0]       ecrd [3];
  logic [2:0]             l_end;
  logic [2:0]             e_end;
  logic [ADDR_W-1:0]      ladr;
  logic [ADDR_W-1:0]      eadr;
  logic                   load_done;
  logic                   load_wr;
  logic                   e_last;

  logic [1:0]             rd_axis;
  logic [ADDR_W-1:0]      stride_sel;
  logic                   lo_ok;
  logic                   hi_ok;
  logic [ADDR_W-1:0]      rd_addr;
  logic [ADDR_W-1:0]      mem_addr;
  logic [MEM_W-1:0]       rdata;
  logic [MEM_W-1:0]       m_vel;

  rd_tag_t                tag0;
  ar_tag_t                tag1;
  ar_tag_t                tag2;
  logic signed [DIFF_W-1:0] diff_c [3];
  logic signed [DIFF_W-1:0] diff   [3];
  logic [RECIP_W-1:0]       rec_sel;
  logic signed [PROD_W-1:0] prod_c [3];
  logic signed [PROD_W-1:0] prod   [3];
  logic signed [PROD_W-1:0] shifted [3];
  jac_mat_t                 stage_jac;

  assign size_wr = cfg_we && (cfg_index == REG_SIZE_X || cfg_index == REG_SIZE_Y ||
                              cfg_index == REG_SIZE_Z);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 3; a++) begin
        size_cfg[a]  <= SIZE_RESET;
        recip_cfg[a] <= RECIP_RESET;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SIZE_X:  size_cfg[0]  <= cfg_data[SIZE_W-1:0];
        REG_SIZE_Y:  size_cfg[1]  <= cfg_data[SIZE_W-1:0];
        REG_SIZE_Z:  size_cfg[2]  <= cfg_data[SIZE_W-1:0];
        REG_RECIP_W: recip_cfg[0] <= cfg_data[RECIP_W-1:0];
        REG_RECIP_H: recip_cfg[1] <= cfg_data[RECIP_W-1:0];
        REG_RECIP_L: recip_cfg[2] <= cfg_data[RECIP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      eff[a]    = eff_size(size_cfg[a]);
      lim_m1[a] = eff[a] - ESZ_W'(1);
      l_end[a]  = (ESZ_W'(lcrd[a]) == lim_m1[a]);
      e_end[a]  = (ESZ_W'(ecrd[a]) == lim_m1[a]);
    end
  end

  assign area    = (2*ESZ_W)'(eff[1]) * (2*ESZ_W)'(eff[2]);
  assign load_wr = cmd.load && !load_done;
  assign e_last  = &e_end;

  always_ff @(posedge clk) begin
    stride_x <= ADDR_W'(area);
  end

  // grid counters, z fastest
  always_ff @(posedge clk) begin
    if (rst || size_wr || (cmd.publish && e_last)) begin
      for (int a = 0; a < 3; a++) begin
        lcrd[a] <= '0;
        ecrd[a] <= '0;
      end
      ladr      <= '0;
      eadr      <= '0;
      load_done <= 1'b0;
    end else begin
      if (load_wr) begin
        ladr    <= ladr + ADDR_W'(1);
        lcrd[2] <= l_end[2] ? '0 : lcrd[2] + CRD_W'(1);
        if (l_end[2]) begin
          lcrd[1] <= l_end[1] ? '0 : lcrd[1] + CRD_W'(1);
        end
        if (l_end[2] && l_end[1]) begin
          lcrd[0] <= l_end[0] ? '0 : lcrd[0] + CRD_W'(1);
        end
        if (&l_end) begin
          load_done <= 1'b1;
        end
      end
      if (cmd.publish) begin
        eadr    <= eadr + ADDR_W'(1);
        ecrd[2] <= e_end[2] ? '0 : ecrd[2] + CRD_W'(1);
        if (e_end[2]) begin
          ecrd[1] <= e_end[1] ? '0 : ecrd[1] + CRD_W'(1);
        end
        if (e_end[2] && e_end[1]) begin
          ecrd[0] <= e_end[0] ? '0 : ecrd[0] + CRD_W'(1);
        end
      end
    end
  end

  assign rd_axis = cmd.rd_step[STEP_W-1:1];

  always_comb begin
    stride_sel = stride_x;
    lo_ok      = (ecrd[0] != '0);
    hi_ok      = !e_end[0];
    case (rd_axis)
      AX_Y: begin
        stride_sel = ADDR_W'(eff[2]);
        lo_ok      = (ecrd[1] != '0);
        hi_ok      = !e_end[1];
      end
      AX_Z: begin
        stride_sel = ADDR_W'(1);
        lo_ok      = (ecrd[2] != '0);
        hi_ok      = !e_end[2];
      end
      default: ;
    endcase
    if (cmd.rd_step[0]) begin
      rd_addr = hi_ok ? eadr + stride_sel : eadr;
    end else begin
      rd_addr = lo_ok ? eadr - stride_sel : eadr;
    end
  end

  assign mem_addr = cmd.load ? ladr : rd_addr;

  vjs_ram #(
    .WIDTH (MEM_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (load_wr),
    .addr  (mem_addr),
    .wdata ({vel_z, vel_y, vel_x}),
    .rdata (rdata)
  );

  always_comb begin
    for (int b = 0; b < 3; b++) begin
      diff_c[b] = {rdata[b*VEL_W + VEL_W-1], rdata[b*VEL_W +: VEL_W]}
                - {m_vel[b*VEL_W + VEL_W-1], m_vel[b*VEL_W +: VEL_W]};
    end
    case (tag1.axis)
      AX_Y:    rec_sel = recip_cfg[1];
      AX_Z:    rec_sel = recip_cfg[2];
      default: rec_sel = recip_cfg[0];
    endcase
    for (int b = 0; b < 3; b++) begin
      prod_c[b]  = PROD_W'(diff[b]) * PROD_W'($signed({1'b0, rec_sel}));
      shifted[b] = tag2.interior ? (prod[b] >>> 1) : prod[b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag0 <= '0;
      tag1 <= '0;
      tag2 <= '0;
    end else begin
      tag0.valid    <= cmd.rd_en;
      tag0.axis     <= rd_axis;
      tag0.hi       <= cmd.rd_step[0];
      tag0.interior <= lo_ok && hi_ok;
      tag1.valid    <= tag0.valid && tag0.hi;
      tag1.axis     <= tag0.axis;
      tag1.interior <= tag0.interior;
      tag2          <= tag1;
    end
  end

  always_ff @(posedge clk) begin
    if (tag0.valid && !tag0.hi) begin
      m_vel <= rdata;
    end
    if (tag0.valid && tag0.hi) begin
      for (int b = 0; b < 3; b++) begin
        diff[b] <= diff_c[b];
      end
    end
    if (tag1.valid) begin
      for (int b = 0; b < 3; b++) begin
        prod[b] <= prod_c[b];
      end
    end
    if (tag2.valid) begin
      for (int b = 0; b < 3; b++) begin
        case (tag2.axis)
          AX_Y:    stage_jac[3+b] <= sat_jac(shifted[b]);
          AX_Z:    stage_jac[6+b] <= sat_jac(shifted[b]);
          default: stage_jac[b]   <= sat_jac(shifted[b]);
        endcase
      end
    end
    if (cmd.publish) begin
      jac       <= stage_jac;
      last_cell <= e_last;
    end
  end

  assign stat.load_done = load_done;
  assign stat.row_done  = tag2.valid && (tag2.axis == AX_Z);

endmodule

`default_nettype wire

>>> sv/velocity_jacobian_stencil_unit.sv
// Top level of the velocity Jacobian stencil unit.
//
//   channel  signals                                   direction
//   in       in_valid/in_ready, req_type, vel_x..vel_z  into the block
//   out      out_valid/out_ready, jac_xx..jac_zz,       out of the block
//            last_cell
//   cfg      cfg_we, cfg_index, cfg_data                into the block, write only
//
// A load transfer leaves the controller idle; the next item can be taken in the following cycle.
// A Jacobian request holds the input through six neighbor reads through the
// single port of the velocity RAM, three arithmetic stages, then the publish step.
// The velocity RAM is not cleared after reset; a full grid is loaded before any read.
// A result waits in the output register while loads continue; a second result
// waits in the controller until the first is taken.
`default_nettype none

module velocity_jacobian_stencil_unit import vjs_pkg::*; #(
  parameter int AXIS_MAX = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic        [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic        [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         req_type,
  input  wire logic signed [VEL_W-1:0]      vel_x,
  input  wire logic signed [VEL_W-1:0]      vel_y,
  input  wire logic signed [VEL_W-1:0]      vel_z,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed      [JAC_W-1:0]      jac_xx,
  output logic signed      [JAC_W-1:0]      jac_xy,
  output logic signed      [JAC_W-1:0]      jac_xz,
  output logic signed      [JAC_W-1:0]      jac_yx,
  output logic signed      [JAC_W-1:0]      jac_yy,
  output logic signed      [JAC_W-1:0]      jac_yz,
  output logic signed      [JAC_W-1:0]      jac_zx,
  output logic signed      [JAC_W-1:0]      jac_zy,
  output logic signed      [JAC_W-1:0]      jac_zz,
  output logic                              last_cell
);

  vjs_cmd_t  cmd;
  vjs_stat_t stat;
  jac_mat_t  jac;

  vjs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .req_type  (req_type),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  vjs_datapath #(
    .AXIS_MAX (AXIS_MAX)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .vel_x     (vel_x),
    .vel_y     (vel_y),
    .vel_z     (vel_z),
    .cmd       (cmd),
    .stat      (stat),
    .jac       (jac),
    .last_cell (last_cell)
  );

  assign jac_xx = signed'(jac[0]);
  assign jac_xy = signed'(jac[1]);
  assign jac_xz = signed'(jac[2]);
  assign jac_yx = signed'(jac[3]);
  assign jac_yy = signed'(jac[4]);
  assign jac_yz = signed'(jac[5]);
  assign jac_zx = signed'(jac[6]);
  assign jac_zy = signed'(jac[7]);
  assign jac_zz = signed'(jac[8]);

`ifndef ASSERT_OFF
  a_pub_needs_grid: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> stat.load_done)
    else $error("result published without a full grid");

  a_no_take_while_read: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> !in_ready)
    else $error("input taken during neighbor reads");

  a_row_latency: assert property (@(posedge clk) disable iff (rst)
    stat.row_done |-> $past(cmd.rd_en, 3))
    else $error("last row finished without a matching read");
`endif

endmodule

`default_nettype wire
